// ===== design/rsdz_pkg.sv =====
package rsdz_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int AXIS_W     = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int SQ_W       = 2 * AXIS_W;
    localparam int LEN_W      = SQ_W / 2;
    localparam int SQRT_STEPS = LEN_W;
    localparam int Q_BITS     = AXIS_W - 1;
    localparam int PROD_W     = AXIS_W + CFG_W;
    localparam int NUM_W      = PROD_W + FRAC_BITS;
    localparam int DEN_W      = CFG_W + LEN_W;
    localparam int DSH_W      = DEN_W + Q_BITS;
    localparam int REM_W      = (NUM_W > DSH_W) ? NUM_W : DSH_W;

    localparam int ONE_VAL    = 1 << FRAC_BITS;
    localparam int QMAX_VAL   = (1 << Q_BITS) - 1;
    localparam int OUT_MAX    = (ONE_VAL < QMAX_VAL) ? ONE_VAL : QMAX_VAL;

    localparam int LATENCY    = 3 + SQRT_STEPS + 3 + Q_BITS + 1;

    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] DEAD_ZONE_RST  = CFG_W'(8000);
    localparam logic [CFG_W-1:0] FULL_SCALE_RST = CFG_W'(30000);

    localparam logic [AXIS_W-1:0] Q_MAX = AXIS_W'(QMAX_VAL);

    typedef struct packed {
        logic [AXIS_W-1:0] mx;
        logic [AXIS_W-1:0] my;
        logic              nx;
        logic              ny;
    } t_axes;

endpackage

// ===== design/radial_stick_dead_zone.sv =====
// radial dead zone with linear rescale, fully pipelined
// throughput: one request per cycle; busy is always low, nothing back-pressures
// stages: abs, square, sum, 16 square-root steps, factor, multiply, divider load, divide stages, output
// reset (i_rst_n low, synchronous): pipeline emptied, dead_zone 8000, full_scale 30000
module radial_stick_dead_zone (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [rsdz_pkg::AXIS_W-1:0]    i_axis_x,
    input  logic signed [rsdz_pkg::AXIS_W-1:0]    i_axis_y,
    input  logic                                  i_cfg_we,
    input  logic [rsdz_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [rsdz_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                  o_valid,
    output logic signed [rsdz_pkg::AXIS_W-1:0]    o_out_x,
    output logic signed [rsdz_pkg::AXIS_W-1:0]    o_out_y
);

    localparam int AW = rsdz_pkg::AXIS_W;
    localparam int SS = rsdz_pkg::SQRT_STEPS;
    localparam int QB = rsdz_pkg::Q_BITS;
    localparam int RW = rsdz_pkg::REM_W;

    typedef struct packed {
        logic [RW-1:0]                  rem_x;
        logic [RW-1:0]                  rem_y;
        logic [QB-1:0]                  q_x;
        logic [QB-1:0]                  q_y;
        logic [rsdz_pkg::DEN_W-1:0]     den;
        logic                           sat_x;
        logic                           sat_y;
        logic                           zero;
        logic                           nx;
        logic                           ny;
    } t_div;

    logic accept;

    logic [rsdz_pkg::CFG_W-1:0] r_dead_zone;
    logic [rsdz_pkg::CFG_W-1:0] r_full_scale;

    logic                  r_v1;
    rsdz_pkg::t_axes       r_a1;
    logic                  r_v2;
    rsdz_pkg::t_axes       r_a2;
    logic [rsdz_pkg::SQ_W-1:0] r_sqx;
    logic [rsdz_pkg::SQ_W-1:0] r_sqy;

    logic                      r_sv  [0:SS];
    rsdz_pkg::t_axes           r_sa  [0:SS];
    logic [rsdz_pkg::SQ_W-1:0] r_rad [0:SS];
    logic [rsdz_pkg::SQ_W-1:0] r_res [0:SS];

    logic [rsdz_pkg::LEN_W-1:0] len;
    logic                       n_zero;
    logic                       degen;
    logic [rsdz_pkg::CFG_W-1:0] span;
    logic [rsdz_pkg::CFG_W-1:0] over;
    logic [rsdz_pkg::CFG_W-1:0] n_num;
    logic [rsdz_pkg::CFG_W-1:0] n_span;

    logic                       r_fv;
    rsdz_pkg::t_axes            r_fa;
    logic [rsdz_pkg::LEN_W-1:0] r_flen;
    logic                       r_fzero;
    logic [rsdz_pkg::CFG_W-1:0] r_fnum;
    logic [rsdz_pkg::CFG_W-1:0] r_fspan;

    logic                        r_mv;
    logic                        r_mzero;
    logic                        r_mnx;
    logic                        r_mny;
    logic [rsdz_pkg::DEN_W-1:0]  r_den;
    logic [rsdz_pkg::PROD_W-1:0] r_px;
    logic [rsdz_pkg::PROD_W-1:0] r_py;

    logic [RW-1:0] num_x;
    logic [RW-1:0] num_y;
    logic [RW-1:0] den_top;

    logic  r_dv [0:QB];
    t_div  r_d  [0:QB];

    logic [AW-1:0] mag_x;
    logic [AW-1:0] mag_y;
    logic          r_ov;
    logic [AW-1:0] r_out_x;
    logic [AW-1:0] r_out_y;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone  <= rsdz_pkg::DEAD_ZONE_RST;
            r_full_scale <= rsdz_pkg::FULL_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rsdz_pkg::REG_DEAD_ZONE:  r_dead_zone  <= i_cfg_data;
                rsdz_pkg::REG_FULL_SCALE: r_full_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid registers outside the square-root and divide loops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_sv[0]  <= 1'b0;
            r_fv     <= 1'b0;
            r_mv     <= 1'b0;
            r_dv[0]  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_v1     <= accept;
            r_v2     <= r_v1;
            r_sv[0]  <= r_v2;
            r_fv     <= r_sv[SS];
            r_mv     <= r_fv;
            r_dv[0]  <= r_mv;
            r_ov     <= r_dv[QB];
        end
    end

    // magnitude and sign, squares, sum
    always_ff @(posedge i_clk) begin
        r_a1.nx   <= i_axis_x[AW-1];
        r_a1.ny   <= i_axis_y[AW-1];
        r_a1.mx   <= i_axis_x[AW-1] ? (~i_axis_x + AW'(1)) : i_axis_x;
        r_a1.my   <= i_axis_y[AW-1] ? (~i_axis_y + AW'(1)) : i_axis_y;
        r_a2      <= r_a1;
        r_sqx     <= r_a1.mx * r_a1.mx;
        r_sqy     <= r_a1.my * r_a1.my;
        r_sa[0]   <= r_a2;
        r_rad[0]  <= r_sqx + r_sqy;
        r_res[0]  <= '0;
    end

    // square root, one result bit per stage
    for (genvar s = 0; s < SS; s++) begin : g_sqrt
        localparam logic [rsdz_pkg::SQ_W-1:0] BIT =
            rsdz_pkg::SQ_W'(1) << (2 * (SS - 1 - s));
        logic [rsdz_pkg::SQ_W-1:0] trial;

        assign trial = r_res[s] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s+1] <= 1'b0;
            end else begin
                r_sv[s+1] <= r_sv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sa[s+1] <= r_sa[s];
            if (r_rad[s] >= trial) begin
                r_rad[s+1] <= r_rad[s] - trial;
                r_res[s+1] <= (r_res[s] >> 1) + BIT;
            end else begin
                r_rad[s+1] <= r_rad[s];
                r_res[s+1] <= r_res[s] >> 1;
            end
        end
    end

    // scale factor as num / span
    assign len    = r_res[SS][rsdz_pkg::LEN_W-1:0];
    assign n_zero = (len < r_dead_zone) || (len == '0);
    assign degen  = r_full_scale <= r_dead_zone;
    assign span   = r_full_scale - r_dead_zone;
    assign over   = len - r_dead_zone;

    always_comb begin
        if (degen) begin
            n_num  = rsdz_pkg::CFG_W'(1);
            n_span = rsdz_pkg::CFG_W'(1);
        end else begin
            n_num  = (over < span) ? over : span;
            n_span = span;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fa    <= r_sa[SS];
        r_flen  <= len;
        r_fzero <= n_zero;
        r_fnum  <= n_num;
        r_fspan <= n_span;
    end

    // numerators and denominator
    always_ff @(posedge i_clk) begin
        r_mzero <= r_fzero;
        r_mnx   <= r_fa.nx;
        r_mny   <= r_fa.ny;
        r_den   <= r_fspan * r_flen;
        r_px    <= r_fa.mx * r_fnum;
        r_py    <= r_fa.my * r_fnum;
    end

    // saturation check and divider load
    assign num_x   = RW'(r_px) << rsdz_pkg::FRAC_BITS;
    assign num_y   = RW'(r_py) << rsdz_pkg::FRAC_BITS;
    assign den_top = RW'(r_den) << QB;

    always_ff @(posedge i_clk) begin
        r_d[0].rem_x <= num_x;
        r_d[0].rem_y <= num_y;
        r_d[0].q_x   <= '0;
        r_d[0].q_y   <= '0;
        r_d[0].den   <= r_den;
        r_d[0].sat_x <= num_x >= den_top;
        r_d[0].sat_y <= num_y >= den_top;
        r_d[0].zero  <= r_mzero;
        r_d[0].nx    <= r_mnx;
        r_d[0].ny    <= r_mny;
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int B = QB - 1 - j;
        logic [RW-1:0] dsh;
        t_div          n_d;

        assign dsh = RW'(r_d[j].den) << B;

        always_comb begin
            n_d = r_d[j];
            if (r_d[j].rem_x >= dsh) begin
                n_d.rem_x  = r_d[j].rem_x - dsh;
                n_d.q_x[B] = 1'b1;
            end
            if (r_d[j].rem_y >= dsh) begin
                n_d.rem_y  = r_d[j].rem_y - dsh;
                n_d.q_y[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else begin
                r_dv[j+1] <= r_dv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_d[j+1] <= n_d;
        end
    end

    // saturate, sign and output register
    assign mag_x = r_d[QB].sat_x ? rsdz_pkg::Q_MAX : AW'(r_d[QB].q_x);
    assign mag_y = r_d[QB].sat_y ? rsdz_pkg::Q_MAX : AW'(r_d[QB].q_y);

    always_ff @(posedge i_clk) begin
        if (r_d[QB].zero) begin
            r_out_x <= '0;
            r_out_y <= '0;
        end else begin
            r_out_x <= r_d[QB].nx ? (AW'(0) - mag_x) : mag_x;
            r_out_y <= r_d[QB].ny ? (AW'(0) - mag_y) : mag_y;
        end
    end

    assign o_valid = r_ov;
    assign o_out_x = r_out_x;
    assign o_out_y = r_out_y;

endmodule

// ===== design/rsdz_checker.sv =====
module rsdz_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic signed [rsdz_pkg::AXIS_W-1:0]    i_axis_x,
    input  logic                                  o_valid,
    input  logic signed [rsdz_pkg::AXIS_W-1:0]    o_out_x,
    input  logic signed [rsdz_pkg::AXIS_W-1:0]    o_out_y
);

    localparam logic signed [rsdz_pkg::AXIS_W-1:0] LIM =
        rsdz_pkg::AXIS_W'(rsdz_pkg::OUT_MAX);
    localparam logic signed [rsdz_pkg::AXIS_W-1:0] NLIM =
        rsdz_pkg::AXIS_W'(-rsdz_pkg::OUT_MAX);

    // every request gives a result
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(rsdz_pkg::LATENCY) o_valid)
        else $error("request without result");

    // no result without a request
    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, rsdz_pkg::LATENCY))
        else $error("result without request");

    // magnitude never beyond one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_x <= LIM) && (o_out_x >= NLIM)
                 && (o_out_y <= LIM) && (o_out_y >= NLIM))
        else $error("output out of range");

    // a non-negative x input gives a non-negative x output
    a_sign_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_axis_x[rsdz_pkg::AXIS_W-1])
            |-> ##(rsdz_pkg::LATENCY) !o_out_x[rsdz_pkg::AXIS_W-1])
        else $error("sign flipped on x");

endmodule

bind radial_stick_dead_zone rsdz_checker u_rsdz_checker (.*);

// ===== test/tb_radial_stick_dead_zone.sv =====
module tb_radial_stick_dead_zone;
    import rsdz_pkg::*;

    localparam int WATCHDOG_LIMIT = 4 * LATENCY + 400;
    localparam int MAX_RADIUS     = 46340;

    typedef struct {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
    } t_stick_out;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic signed [AXIS_W-1:0]    i_axis_x;
    logic signed [AXIS_W-1:0]    i_axis_y;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_idx;
    logic [CFG_W-1:0]            i_cfg_data;
    logic                        o_valid;
    logic signed [AXIS_W-1:0]    o_out_x;
    logic signed [AXIS_W-1:0]    o_out_y;

    logic [CFG_W-1:0] dead_zone_cfg;
    logic [CFG_W-1:0] full_scale_cfg;
    t_stick_out       pending_outputs[$];
    int               mismatches;
    int               requests_sent;
    int               results_checked;
    int               settings_used;
    int               idle_cycles = 0;

    radial_stick_dead_zone dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_axis_x   (i_axis_x),
        .i_axis_y   (i_axis_y),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [AXIS_W-1:0] scale_axis_value(input longint unsigned mag,
                                                                   input bit neg,
                                                                   input longint unsigned num,
                                                                   input longint unsigned den);
        longint unsigned q;
        logic [AXIS_W-1:0] m;
        q = ((mag * num) << FRAC_BITS) / den;
        if (q > QMAX_VAL) q = QMAX_VAL;
        m = q[AXIS_W-1:0];
        return neg ? -m : m;
    endfunction

    function automatic t_stick_out condition_stick(input logic signed [AXIS_W-1:0] ax,
                                                   input logic signed [AXIS_W-1:0] ay);
        t_stick_out res;
        longint sx;
        longint sy;
        longint unsigned mx;
        longint unsigned my;
        longint unsigned len;
        longint unsigned num;
        longint unsigned den;
        longint unsigned span;
        longint unsigned over;
        sx = ax;
        sy = ay;
        mx = (sx < 0) ? -sx : sx;
        my = (sy < 0) ? -sy : sy;
        len = floor_root(mx * mx + my * my);
        res.x = '0;
        res.y = '0;
        if (len >= dead_zone_cfg && len != 0) begin
            if (full_scale_cfg <= dead_zone_cfg) begin
                num = 1;
                den = 1;
            end else begin
                span = full_scale_cfg - dead_zone_cfg;
                over = len - dead_zone_cfg;
                num  = (over < span) ? over : span;
                den  = span;
            end
            den = den * len;
            res.x = scale_axis_value(mx, sx < 0, num, den);
            res.y = scale_axis_value(my, sy < 0, num, den);
        end
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic logic signed [AXIS_W-1:0] corner_value(input int k);
        case (k)
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            default: return 32767;
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_stick_out want;
        if (i_rst_n && o_valid) begin
            if (pending_outputs.size() == 0) begin
                note_failure($sformatf("result x=%0d y=%0d with no request pending",
                                       o_out_x, o_out_y));
            end else begin
                want = pending_outputs.pop_front();
                results_checked++;
                if (o_out_x !== want.x)
                    note_failure($sformatf("out_x expected %0d got %0d", want.x, o_out_x));
                if (o_out_y !== want.y)
                    note_failure($sformatf("out_y expected %0d got %0d", want.y, o_out_y));
            end
        end
    end

    // watchdog on cycles with no request and no result
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_sample(input logic signed [AXIS_W-1:0] x,
                               input logic signed [AXIS_W-1:0] y);
        @(negedge i_clk);
        start    <= 1'b1;
        i_axis_x <= x;
        i_axis_y <= y;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_outputs.push_back(condition_stick(x, y));
        requests_sent++;
    endtask

    task automatic idle_burst();
        int n;
        n = $urandom_range(1, 5);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    task automatic set_knobs(input logic [CFG_W-1:0] dz, input logic [CFG_W-1:0] fs);
        wait_results_done();
        write_reg(REG_DEAD_ZONE, dz);
        write_reg(REG_FULL_SCALE, fs);
        @(negedge i_clk);
        i_cfg_we       <= 1'b0;
        dead_zone_cfg  = dz;
        full_scale_cfg = fs;
        settings_used++;
    endtask

    task automatic next_sample(output logic signed [AXIS_W-1:0] x,
                               output logic signed [AXIS_W-1:0] y);
        int mode;
        longint unsigned r;
        longint unsigned mx;
        longint unsigned my;
        mode = $urandom_range(0, 9);
        if (mode <= 2) begin
            x = AXIS_W'($urandom);
            y = AXIS_W'($urandom);
        end else if (mode <= 6) begin
            // points on a circle around the dead zone, full scale or anywhere
            case ($urandom_range(0, 2))
                0:       r = dead_zone_cfg;
                1:       r = full_scale_cfg;
                default: r = $urandom_range(0, MAX_RADIUS);
            endcase
            r = r + $urandom_range(0, 4);
            r = (r >= 2) ? r - 2 : 0;
            if (r > MAX_RADIUS) r = MAX_RADIUS;
            mx = $urandom_range(0, int'((r > 32767) ? 32767 : r));
            my = floor_root(r * r - mx * mx);
            if (my > 32767) my = 32767;
            x = AXIS_W'(mx);
            y = AXIS_W'(my);
            if ($urandom_range(0, 1)) x = -x;
            if ($urandom_range(0, 1)) y = -y;
        end else if (mode == 7) begin
            x = corner_value($urandom_range(0, 5));
            y = corner_value($urandom_range(0, 5));
        end else begin
            x = AXIS_W'($urandom_range(0, 2000));
            y = AXIS_W'($urandom_range(0, 2000));
            if ($urandom_range(0, 1)) x = -x;
            if ($urandom_range(0, 1)) y = -y;
        end
    endtask

    task automatic run_random_phase(input int count, input bit with_gaps);
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        repeat (count) begin
            next_sample(x, y);
            send_sample(x, y);
            if (with_gaps && $urandom_range(0, 4) == 0) idle_burst();
        end
    endtask

    task automatic test_reset_values();
        // register values straight out of reset
        send_sample(0, 0);
        send_sample(7999, 0);
        send_sample(8000, 0);
        send_sample(0, -8001);
        send_sample(30000, 0);
        send_sample(32767, 32767);
        send_sample(-32768, -32768);
        send_sample(-32768, 0);
        send_sample(21213, -21213);
        send_sample(12000, -5000);
    endtask

    task automatic test_zero_dead_zone();
        set_knobs(0, 30000);
        send_sample(0, 0);
        send_sample(1, 0);
        send_sample(-1, 1);
        send_sample(0, -32768);
    endtask

    task automatic test_degenerate_range();
        set_knobs(500, 500);
        send_sample(500, 0);
        send_sample(-300, -400);
        send_sample(32767, -32768);
        set_knobs(500, 0);
        send_sample(1000, 1000);
    endtask

    task automatic test_large_dead_zone();
        set_knobs(46341, 65535);
        send_sample(32767, 32767);
        send_sample(-32768, -32768);
        set_knobs(65535, 0);
        send_sample(-32768, -32768);
    endtask

    task automatic test_drain_pause();
        // stream, stop until the pipeline is empty, stream again
        set_knobs(8000, 30000);
        run_random_phase(60, 1'b0);
        wait_results_done();
        run_random_phase(60, 1'b1);
    endtask

    task automatic test_random_sweep();
        set_knobs(0, 46341);
        run_random_phase(170, 1'b1);
        set_knobs(1, 1);
        run_random_phase(150, 1'b1);
        set_knobs(46341, 65535);
        run_random_phase(60, 1'b1);
        set_knobs(300, 0);
        run_random_phase(150, 1'b1);
        set_knobs(65535, 65535);
        run_random_phase(50, 1'b1);
        set_knobs(1, 46341);
        run_random_phase(150, 1'b1);
        repeat (2) begin
            set_knobs(CFG_W'($urandom_range(0, MAX_RADIUS + 1)),
                      CFG_W'($urandom_range(0, 65535)));
            run_random_phase(120, 1'b1);
        end
    endtask

    task automatic test_random_streaming();
        set_knobs(4000, 20000);
        run_random_phase(180, 1'b0);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_axis_x        = '0;
        i_axis_y        = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        dead_zone_cfg   = DEAD_ZONE_RST;
        full_scale_cfg  = FULL_SCALE_RST;
        mismatches      = 0;
        requests_sent   = 0;
        results_checked = 0;
        settings_used   = 1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_zero_dead_zone();
        test_degenerate_range();
        test_large_dead_zone();
        test_drain_pause();
        test_random_sweep();
        test_random_streaming();

        wait_results_done();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (pending_outputs.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_outputs.size()));

        $display("%0d stick samples sent over %0d register settings, %0d results checked",
                 requests_sent, settings_used, results_checked);
        $display("dead zone 0 to 65535, degenerate and saturating ranges; %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
